// ===== design/ofdmpi_pkg.sv =====
// shared constants, payload types and tone classification for the pilot insertion block
package ofdmpi_pkg;

  localparam int STREAMS     = 4;
  localparam int SUBCARRIERS = 256;
  localparam int PILOTS      = 8;
  localparam int MAX_RESULTS = 7;

  localparam int SAMPLE_W = 16;
  localparam int AMP_W    = 15;
  localparam int POS_W    = $clog2(SUBCARRIERS);
  localparam int ROT_W    = $clog2(PILOTS);
  localparam int CNT_W    = $clog2(MAX_RESULTS);

  localparam logic [AMP_W-1:0] AMP_RESET      = AMP_W'(8192);
  // highest position that still carries data; past it only trailing guard nulls remain
  localparam logic [POS_W-1:0] LAST_DATA_POS  = POS_W'(250);
  localparam logic [POS_W-1:0] LAST_POS       = POS_W'(SUBCARRIERS - 1);
  // sign pattern of the pilots, bit set means negative
  localparam logic [PILOTS-1:0] PILOT_NEG     = 8'b0001_1000;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PILOT = 2'd1,
    KIND_NULL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] data_i_lane0;
    logic signed [SAMPLE_W-1:0] data_q_lane0;
    logic signed [SAMPLE_W-1:0] data_i_lane1;
    logic signed [SAMPLE_W-1:0] data_q_lane1;
    logic signed [SAMPLE_W-1:0] data_i_lane2;
    logic signed [SAMPLE_W-1:0] data_q_lane2;
    logic signed [SAMPLE_W-1:0] data_i_lane3;
    logic signed [SAMPLE_W-1:0] data_q_lane3;
    logic                       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i_lane0;
    logic signed [SAMPLE_W-1:0] out_q_lane0;
    logic signed [SAMPLE_W-1:0] out_i_lane1;
    logic signed [SAMPLE_W-1:0] out_q_lane1;
    logic signed [SAMPLE_W-1:0] out_i_lane2;
    logic signed [SAMPLE_W-1:0] out_q_lane2;
    logic signed [SAMPLE_W-1:0] out_i_lane3;
    logic signed [SAMPLE_W-1:0] out_q_lane3;
    logic [POS_W-1:0]           subcarrier_index;
    logic [1:0]                 tone_kind;
    logic                       last_of_run;
    logic                       symbol_end;
  } out_item_t;

  // per-tone control info from the tone generator to the sequencer
  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] next_pos;
    logic             wrap;
    logic             tail;
  } tone_class_t;

  // zero-based positions: guard and dc nulls, then pilots
  function automatic kind_t classify(input logic [POS_W-1:0] pos);
    kind_t k;
    case (pos) inside
      [8'd0:8'd5], [8'd127:8'd129], [8'd251:8'd255]: k = KIND_NULL;
      8'd25, 8'd53, 8'd89, 8'd117, 8'd139, 8'd167, 8'd203, 8'd231: k = KIND_PILOT;
      default: k = KIND_DATA;
    endcase
    return k;
  endfunction

  function automatic logic [ROT_W-1:0] pilot_index(input logic [POS_W-1:0] pos);
    logic [ROT_W-1:0] p;
    case (pos)
      8'd25:   p = 3'd0;
      8'd53:   p = 3'd1;
      8'd89:   p = 3'd2;
      8'd117:  p = 3'd3;
      8'd139:  p = 3'd4;
      8'd167:  p = 3'd5;
      8'd203:  p = 3'd6;
      8'd231:  p = 3'd7;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== design/ofdmpi_if.sv =====
// valid/ready channel interfaces for input data tones and mapped output tones
interface ofdmpi_in_if;
  logic                 valid;
  logic                 ready;
  ofdmpi_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface ofdmpi_out_if;
  logic                  valid;
  logic                  ready;
  ofdmpi_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== design/ofdmpi_tone_gen.sv =====
// combinational tone builder: classifies the current position and forms its values
module ofdmpi_tone_gen (
  input  logic [ofdmpi_pkg::POS_W-1:0] pos,
  input  logic [ofdmpi_pkg::ROT_W-1:0] rot,
  input  logic [ofdmpi_pkg::AMP_W-1:0] amp,
  input  ofdmpi_pkg::in_item_t         item,
  output ofdmpi_pkg::tone_class_t      cls,
  output ofdmpi_pkg::out_item_t        tone
);
  import ofdmpi_pkg::*;

  kind_t                kind;
  logic [ROT_W-1:0]     sel;
  logic [SAMPLE_W-1:0]  mag;
  logic [SAMPLE_W-1:0]  pilot_i;

  always_comb begin
    kind    = classify(pos);
    sel     = pilot_index(pos) + rot;
    mag     = {1'b0, amp};
    pilot_i = PILOT_NEG[sel] ? (SAMPLE_W'(0) - mag) : mag;

    tone = '0;
    case (kind)
      KIND_DATA: begin
        if (STREAMS > 0) begin
          tone.out_i_lane0 = item.data_i_lane0;
          tone.out_q_lane0 = item.data_q_lane0;
        end
        if (STREAMS > 1) begin
          tone.out_i_lane1 = item.data_i_lane1;
          tone.out_q_lane1 = item.data_q_lane1;
        end
        if (STREAMS > 2) begin
          tone.out_i_lane2 = item.data_i_lane2;
          tone.out_q_lane2 = item.data_q_lane2;
        end
        if (STREAMS > 3) begin
          tone.out_i_lane3 = item.data_i_lane3;
          tone.out_q_lane3 = item.data_q_lane3;
        end
      end
      KIND_PILOT: begin
        if (STREAMS > 0) tone.out_i_lane0 = pilot_i;
        if (STREAMS > 1) tone.out_i_lane1 = pilot_i;
        if (STREAMS > 2) tone.out_i_lane2 = pilot_i;
        if (STREAMS > 3) tone.out_i_lane3 = pilot_i;
      end
      default: begin
      end
    endcase
    tone.subcarrier_index = pos;
    tone.tone_kind        = kind;
    tone.last_of_run      = 1'b0;
    tone.symbol_end       = (pos == LAST_POS);

    cls.kind     = kind;
    cls.next_pos = pos + POS_W'(1);
    cls.wrap     = (cls.next_pos == '0);
    cls.tail     = (cls.next_pos > LAST_DATA_POS);
  end

endmodule

// ===== design/ofdm_pilot_insert_subcarrier_map_core.sv =====
// top level: pilot insertion and 80 mhz subcarrier mapping, one tone per cycle while dout is ready
// a request is held in the request register, and each of its tones is registered in the output slot
// throughput: one output tone per cycle while dout is ready; a request causes 1 to 7 tones
//   (256 tones per 234 data requests in steady state), set by the single tone slot
// reset (rst, synchronous, active high): position 0, rotation 0, amplitude 8192,
//   both channels empty; payload registers are not reset
module ofdm_pilot_insert_subcarrier_map_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ofdmpi_pkg::AMP_W-1:0] cfg_wr_data,
  ofdmpi_in_if.sink                    din,
  ofdmpi_out_if.source                 dout
);
  import ofdmpi_pkg::*;

  // configuration
  logic [AMP_W-1:0] amp;

  // held request and its walk state
  in_item_t         item;
  logic             item_valid;
  logic [POS_W-1:0] pos;
  logic [ROT_W-1:0] rot;
  logic [CNT_W-1:0] cnt;
  logic             trailing;

  // output slot
  out_item_t        out_item;
  logic             out_valid;

  tone_class_t      cls;
  out_item_t        tone;
  out_item_t        tone_final;
  logic             emit;
  logic             last;
  logic             accept;

  ofdmpi_tone_gen u_tone_gen (
    .pos  (pos),
    .rot  (rot),
    .amp  (amp),
    .item (item),
    .cls  (cls),
    .tone (tone)
  );

  // a tone leaves the held request whenever the output slot is free or draining
  assign emit = item_valid && (!out_valid || dout.ready);

  // run ends at the data tone, unless only guard nulls are left in the symbol,
  // in which case it ends at the symbol wrap; never more than seven tones
  always_comb begin
    if (cnt == CNT_W'(MAX_RESULTS - 1)) begin
      last = 1'b1;
    end else if (trailing) begin
      last = cls.wrap;
    end else begin
      last = (cls.kind == KIND_DATA) && !cls.tail;
    end
  end

  // tone as it goes out, marked when it closes the run
  always_comb begin
    tone_final             = tone;
    tone_final.last_of_run = last;
  end

  // next request is taken when none is held, or in the cycle the current one emits its final tone
  assign din.ready  = !item_valid || (emit && last);
  assign accept     = din.valid && din.ready;

  assign dout.valid = out_valid;
  assign dout.item  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp        <= AMP_RESET;
      item_valid <= 1'b0;
      pos        <= '0;
      rot        <= '0;
      cnt        <= '0;
      trailing   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        amp <= cfg_wr_data;
      end

      // position walk; rotation steps at each new symbol
      if (emit) begin
        pos <= cls.next_pos;
        if (cls.wrap) begin
          rot <= rot + ROT_W'(1);
        end
      end
      // frame start abandons any partial symbol
      if (accept && din.item.frame_start) begin
        pos <= '0;
        rot <= '0;
      end

      if (accept) begin
        cnt <= '0;
      end else if (emit) begin
        cnt <= cnt + CNT_W'(1);
      end

      // trailing guard phase follows the last data tone of a symbol
      if (accept || (emit && last)) begin
        trailing <= 1'b0;
      end else if (emit && cls.kind == KIND_DATA && cls.tail) begin
        trailing <= 1'b1;
      end

      if (accept) begin
        item_valid <= 1'b1;
      end else if (emit && last) begin
        item_valid <= 1'b0;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= din.item;
    end
    if (emit) begin
      out_item <= tone_final;
    end
  end

`ifndef SYNTH
  // trailing phase only while the walk sits in the upper guard band
  assert property (@(posedge clk) disable iff (rst)
    trailing |-> (pos > LAST_DATA_POS))
    else $error("trailing phase outside upper guard band");

  // a held request never emits more than the run limit
  assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (cnt < CNT_W'(MAX_RESULTS)))
    else $error("tone count beyond run limit");

  // a new request starts a fresh run
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (item_valid && cnt == '0 && !trailing))
    else $error("accepted request did not start a fresh run");

  // the final tone releases the request slot
  assert property (@(posedge clk) disable iff (rst)
    (emit && last && !accept) |=> !item_valid)
    else $error("request slot held after final tone");
`endif

endmodule
